// ===== design/r0s_pkg.sv =====
// Package: shared widths, result codes, controller states and control structs.
package r0s_pkg;

	localparam int ADDR_W     = 48;
	localparam int LEN_W      = 17;
	localparam int ROW_W      = 36;
	localparam int DEVIDX_W   = 4;
	localparam int CLEN_W     = 13;
	localparam int DCNT_W     = 5;
	localparam int S_TDATA_W  = 120;
	localparam int M_TDATA_W  = 120;
	localparam int M_TUSER_W  = 3;

	localparam logic CFG_DEVICE_COUNT = 1'b0;
	localparam logic CFG_REGION_BASE  = 1'b1;

	localparam logic [1:0] RES_CHUNK      = 2'd0;
	localparam logic [1:0] RES_WR_ZERO    = 2'd1;
	localparam logic [1:0] RES_RD_EMPTY   = 2'd2;
	localparam logic [1:0] RES_BELOW_BASE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1,
		ST_EMIT,
		ST_ERR
	} r0s_state_t;

	typedef struct packed {
		logic ld_req;
		logic setup;
		logic div_start;
		logic row_ld;
		logic dev_ld;
		logic emit;
		logic err_emit;
	} r0s_cmd_t;

	typedef struct packed {
		logic reject;
		logic div_done;
		logic last_chunk;
		logic out_free;
	} r0s_sts_t;

endpackage

// ===== design/r0s_div.sv =====
// Restoring divider: one quotient bit per cycle over a 48-bit dividend.
module r0s_div #(
	parameter int DVS_W = 26
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [r0s_pkg::ADDR_W-1:0] dividend,
	input  logic [DVS_W-1:0]           divisor,
	output logic                       done,
	output logic [r0s_pkg::ADDR_W-1:0] quotient,
	output logic [DVS_W-1:0]           remainder
);
	import r0s_pkg::*;

	localparam int CNT_W = $clog2(ADDR_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ADDR_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] num_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, num_q[ADDR_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[ADDR_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

// ===== design/r0s_datapath.sv =====
// Datapath: configuration, request registers, stripe stepping and output register.
module r0s_datapath #(
	parameter int STRIPE_BLOCK_BYTES = 4096,
	parameter int MAX_DEVICES        = 16,
	parameter int MAX_REQUEST_BLOCKS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  r0s_pkg::r0s_cmd_t             cmd,
	output r0s_pkg::r0s_sts_t             sts,
	input  logic                          s_tuser,
	input  logic [r0s_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [r0s_pkg::ADDR_W-1:0]    cfg_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [r0s_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [r0s_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                          m_tlast
);
	import r0s_pkg::*;

	localparam int IB_W   = $clog2(STRIPE_BLOCK_BYTES);
	localparam int BLK_W  = $clog2(STRIPE_BLOCK_BYTES + 1);
	localparam int CMP_W  = (BLK_W > LEN_W) ? BLK_W : LEN_W;
	localparam int DEV_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int NDV_W  = $clog2(MAX_DEVICES + 1);
	localparam int NC_W   = (NDV_W > DCNT_W) ? NDV_W : DCNT_W;
	localparam int DVS_W  = $clog2(STRIPE_BLOCK_BYTES * MAX_DEVICES + 1);
	localparam logic [NC_W-1:0]   MAXD     = NC_W'(MAX_DEVICES);
	localparam logic [NC_W-1:0]   ONE_DEV  = NC_W'(1);
	localparam logic [ADDR_W-1:0] BLK_A    = ADDR_W'(STRIPE_BLOCK_BYTES);
	localparam logic [CMP_W-1:0]  BLK_C    = CMP_W'(STRIPE_BLOCK_BYTES);
	localparam logic [DVS_W-1:0]  BLK_D    = DVS_W'(STRIPE_BLOCK_BYTES);
	localparam logic [31:0]       MAX_LEN  = 32'(MAX_REQUEST_BLOCKS * STRIPE_BLOCK_BYTES);

	logic [DCNT_W-1:0] dcount_q;
	logic [ADDR_W-1:0] base_cfg_q;

	logic              dir_q;
	logic [ADDR_W-1:0] vaddr_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] host_q;
	logic [LEN_W-1:0]  rem_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [DEV_W-1:0]  dev_q;
	logic [IB_W-1:0]   inblk_q;

	logic                out_valid_q;
	logic                out_dir_q;
	logic [DEVIDX_W-1:0] out_dev_q;
	logic [ADDR_W-1:0]   out_off_q;
	logic [CLEN_W-1:0]   out_len_q;
	logic [ADDR_W-1:0]   out_host_q;
	logic [1:0]          out_res_q;
	logic                out_last_q;

	logic [NC_W-1:0]   dc_ext;
	logic [NC_W-1:0]   ndev;
	logic [NC_W-1:0]   dev_inc;
	logic [ADDR_W-1:0] pos;
	logic [LEN_W-1:0]  len_sat;
	logic [ADDR_W-1:0] div_num;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [ADDR_W-1:0] div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic [ROW_W-1:0]  row_new;
	logic [CMP_W-1:0]  room;
	logic [CMP_W-1:0]  rem_c;
	logic [CMP_W-1:0]  chunk;
	logic              last_chunk;
	logic [ADDR_W-1:0] doff;

	assign dc_ext  = NC_W'(dcount_q);
	assign ndev    = (dcount_q == '0) ? ONE_DEV : ((dc_ext > MAXD) ? MAXD : dc_ext);
	assign dev_inc = NC_W'(dev_q) + ONE_DEV;
	assign pos     = vaddr_q - base_cfg_q;
	assign len_sat = ({15'b0, len_q} > MAX_LEN) ? LEN_W'(MAX_LEN) : len_q;
	assign div_num = pos;
	assign div_dvs = DVS_W'(BLK_D * DVS_W'(ndev));
	assign row_new = div_quo[ROW_W-1:0];

	assign room       = BLK_C - CMP_W'(inblk_q);
	assign rem_c      = CMP_W'(rem_q);
	assign chunk      = (room < rem_c) ? room : rem_c;
	assign last_chunk = chunk == rem_c;
	assign doff       = row_base_q + ADDR_W'(inblk_q);

	r0s_div #(
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcount_q   <= DCNT_W'(1);
			base_cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEVICE_COUNT: dcount_q   <= cfg_data[DCNT_W-1:0];
				CFG_REGION_BASE:  base_cfg_q <= cfg_data;
				default:          dcount_q   <= dcount_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			dir_q   <= s_tuser;
			vaddr_q <= s_tdata[ADDR_W-1:0];
			len_q   <= s_tdata[ADDR_W+LEN_W-1:ADDR_W];
			host_q  <= s_tdata[2*ADDR_W+LEN_W-1:ADDR_W+LEN_W];
		end
		if (cmd.setup) begin
			rem_q <= len_sat;
		end
		if (cmd.row_ld) begin
			row_q      <= row_new;
			row_base_q <= ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, row_new} << IB_W);
		end
		if (cmd.dev_ld) begin
			dev_q   <= div_rem[IB_W +: DEV_W];
			inblk_q <= div_rem[IB_W-1:0];
		end
		if (cmd.emit) begin
			rem_q   <= rem_q - chunk[LEN_W-1:0];
			host_q  <= host_q + ADDR_W'(chunk);
			inblk_q <= '0;
			if (!last_chunk) begin
				if (dev_inc >= ndev) begin
					dev_q      <= '0;
					row_q      <= row_q + 1'b1;
					row_base_q <= (row_q == '1) ? '0 : row_base_q + BLK_A;
				end else begin
					dev_q <= dev_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.err_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_dir_q  <= dir_q;
			out_dev_q  <= DEVIDX_W'(dev_q);
			out_off_q  <= doff;
			out_len_q  <= CLEN_W'(chunk);
			out_host_q <= host_q;
			out_res_q  <= RES_CHUNK;
			out_last_q <= last_chunk;
		end else if (cmd.err_emit) begin
			out_dir_q  <= dir_q;
			out_dev_q  <= '0;
			out_off_q  <= '0;
			out_len_q  <= '0;
			out_host_q <= '0;
			out_last_q <= 1'b1;
			if (len_q == '0) begin
				out_res_q <= dir_q ? RES_WR_ZERO : RES_RD_EMPTY;
			end else begin
				out_res_q <= RES_BELOW_BASE;
			end
		end
	end

	assign sts.reject     = (len_q == '0) || (vaddr_q < base_cfg_q);
	assign sts.div_done   = div_done;
	assign sts.last_chunk = last_chunk;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_host_q, out_len_q, out_off_q, out_dev_q};
	assign m_tuser  = {out_res_q, out_dir_q};
	assign m_tlast  = out_last_q;

	a_emit_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (rem_q != '0) && (chunk != '0))
		else $error("chunk emitted with no bytes left");

	a_dev_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (NC_W'(dev_q) < ndev))
		else $error("device index beyond device count");

	a_one_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.err_emit) |-> sts.out_free && !(cmd.emit && cmd.err_emit))
		else $error("output register overwritten");

endmodule

// ===== design/r0s_ctrl.sv =====
// Controller: request sequencing through check, one divider pass and chunk or error emission.
module r0s_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  r0s_pkg::r0s_sts_t sts,
	output r0s_pkg::r0s_cmd_t cmd
);
	import r0s_pkg::*;

	r0s_state_t state_q;
	r0s_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.reject ? ST_ERR : ST_DIV1;
			end
			ST_DIV1: begin
				if (sts.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.last_chunk) state_d = ST_IDLE;
			end
			ST_ERR: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.ld_req = s_tvalid;
			end
			ST_CHECK: begin
				cmd.setup     = !sts.reject;
				cmd.div_start = !sts.reject;
			end
			ST_DIV1: begin
				cmd.row_ld = sts.div_done;
				cmd.dev_ld = sts.div_done;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			ST_ERR: begin
				cmd.err_emit = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_CHECK))
		else $error("accepted transfer not checked");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_DIV1) |-> !s_tready)
		else $error("input taken during a request");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.err_emit |=> (state_q == ST_IDLE))
		else $error("error result not single");

endmodule

// ===== design/raid0_stripe_request_splitter.sv =====
// Top level: RAID-0 stripe request splitter, controller plus datapath.
//
//  channel  | direction | signals                        | payload
//  ---------+-----------+--------------------------------+------------------------------
//  s        | in        | s_tvalid s_tready s_tdata/user | one request
//  m        | out       | m_tvalid m_tready m_tdata/user | one chunk or error, m_tlast
//  cfg      | in        | cfg_valid cfg_ready            | cfg_index, cfg_data
//
// A request goes through the check state, one pass of the one-bit-per-cycle divider by
// block size times device count, one chunk per cycle while the output is not stalled,
// and back to the idle state, where the next transfer is taken. Zero-length and
// below-base requests give their single result through the check and error states.
// Reset clears the controller, the divider control and the output valid flag.
// A stalled output holds the chunk sequence; input is taken only between requests.
module raid0_stripe_request_splitter #(
	parameter int STRIPE_BLOCK_BYTES = 4096,
	parameter int MAX_DEVICES        = 16,
	parameter int MAX_REQUEST_BLOCKS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// volume_address, byte_length, host_address
	input  logic [r0s_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// device_index, device_offset, chunk_length, chunk_host_address
	output logic [r0s_pkg::M_TDATA_W-1:0] m_tdata,
	// direction, status
	output logic [r0s_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [r0s_pkg::ADDR_W-1:0]    cfg_data
);
	import r0s_pkg::*;

	r0s_cmd_t cmd;
	r0s_sts_t sts;

	assign cfg_ready = 1'b1;

	r0s_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	r0s_datapath #(
		.STRIPE_BLOCK_BYTES(STRIPE_BLOCK_BYTES),
		.MAX_DEVICES       (MAX_DEVICES),
		.MAX_REQUEST_BLOCKS(MAX_REQUEST_BLOCKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
